// ===== hdl/rgb_to_bitplane_packer_top_assert.svh =====
// Assertion macros used by the packer back stage (rtbp_back).
`ifndef RGB_TO_BITPLANE_PACKER_TOP_ASSERT_SVH
`define RGB_TO_BITPLANE_PACKER_TOP_ASSERT_SVH
`ifndef SYNTH
`define RTBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RTBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTBP_ASSERT(lbl, prop, msg)
`define RTBP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/rtbp_pkg.sv =====
// Types, constants and the pixel classifier for the bitplane packer.
package rtbp_pkg;

  localparam int ROW_W       = 11;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] RED_MIN_LEVEL = 8'd64;
  localparam logic [7:0] BLACK_LEVEL   = 8'd127;

  localparam logic CFG_TARGET_PLANE = 1'b0;
  localparam logic CFG_LINE_PIXELS  = 1'b1;

  localparam logic PLANE_BW  = 1'b0;
  localparam logic PLANE_RED = 1'b1;

  typedef struct packed {
    logic             target_plane;
    logic [ROW_W-1:0] line_pixels;
  } cfg_t;

  // plane bit of one pixel: red plane marks red pixels, bw plane marks red or non-black
  function automatic logic plane_bit(input logic [7:0] b, input logic [7:0] g,
                                     input logic [7:0] r, input logic plane);
    logic [7:0] half;
    logic       is_red;
    logic       is_black;
    half     = r >> 1;
    is_red   = (b < half) && (g < half) && (r > RED_MIN_LEVEL);
    is_black = (b < BLACK_LEVEL) && (g < BLACK_LEVEL) && (r < BLACK_LEVEL);
    if (plane == PLANE_RED) begin
      return is_red;
    end
    return is_red || !is_black;
  endfunction

endpackage

// ===== hdl/rtbp_front.sv =====
// Front stage: accepts pixels and reduces each to its plane bit.
module rtbp_front import rtbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  input  logic       target_plane,
  output logic       push,
  output logic       push_bit,
  input  logic       q_full
);

  logic hold_valid;
  logic hold_bit;

  assign in_stall = hold_valid && q_full;
  assign push     = hold_valid;
  assign push_bit = hold_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_bit <= plane_bit(blue, green, red, target_plane);
    end
  end

endmodule

// ===== hdl/rtbp_queue.sv =====
// Short bit queue between the classifier and the packer.
module rtbp_queue import rtbp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic push_bit,
  output logic full,
  input  logic pop,
  output logic pop_bit,
  output logic not_empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [QUEUE_DEPTH-1:0] store;
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_bit   = store[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= CNT_W'(count + 1'b1);
        2'b01:   count <= CNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/rtbp_back.sv =====
// Back stage: packs plane bits MSB first and emits bytes at byte or row end.
module rtbp_back import rtbp_pkg::*; #(
  parameter int MAX_ROW_PIXELS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [ROW_W-1:0] line_pixels,
  input  logic             q_valid,
  input  logic             q_bit,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       packed_bits,
  output logic             row_done
);

  `include "rgb_to_bitplane_packer_top_assert.svh"

  localparam int CNT_W = $clog2(MAX_ROW_PIXELS);
  localparam int CMP_W = ($clog2(MAX_ROW_PIXELS + 1) > ROW_W) ?
                         $clog2(MAX_ROW_PIXELS + 1) : ROW_W;

  logic [7:0]       acc;
  logic [2:0]       bpos;
  logic [CNT_W-1:0] col;
  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] width_ext;
  logic [7:0]       acc_next;
  logic             row_end;
  logic             emit;

  assign width_ext = CMP_W'(line_pixels);

  // zero width acts as one, oversized width saturates
  always_comb begin
    if (width_ext == '0) begin
      width_eff = CMP_W'(1);
    end else if (width_ext > CMP_W'(MAX_ROW_PIXELS)) begin
      width_eff = CMP_W'(MAX_ROW_PIXELS);
    end else begin
      width_eff = width_ext;
    end
  end

  assign pop      = q_valid && (!out_valid || !out_stall);
  assign acc_next = acc | (8'(q_bit) << bpos);
  assign row_end  = (CMP_W'(col) + CMP_W'(1)) >= width_eff;
  assign emit     = pop && ((bpos == 3'd0) || row_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      bpos      <= 3'd7;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (emit) begin
          acc  <= '0;
          bpos <= 3'd7;
          col  <= row_end ? '0 : CNT_W'(col + 1'b1);
        end else begin
          acc  <= acc_next;
          bpos <= 3'(bpos - 3'd1);
          col  <= CNT_W'(col + 1'b1);
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      packed_bits <= acc_next;
      row_done    <= row_end;
    end
  end

  `RTBP_ASSERT(a_idle_holds,
               !pop |=> $stable(col) && $stable(bpos),
               "packer state moved without a bit")
  `RTBP_ASSERT(a_row_end_clears,
               out_valid && out_stall && row_done |-> col == '0 && bpos == 3'd7,
               "row end byte pending but column not cleared")
  `RTBP_ASSERT(a_bit_step,
               pop && !emit |=> bpos == 3'($past(bpos) - 3'd1),
               "bit position did not step down")

endmodule

// ===== hdl/rgb_to_bitplane_packer_top.sv =====
// Top level of the RGB to bitplane packer: config registers and stage wiring.
//
// Input channel: one pixel (blue, green, red) per beat, taken when in_valid is
// high and in_stall is low. Output channel: one packed byte per beat with
// row_done set on the last byte of a row, taken when out_valid is high and
// out_stall is low. A byte leaves after eight pixels or at a row end; a
// partial byte is zero padded in its low bits.
// A pixel is accepted every cycle while in_stall is low. The byte a pixel
// completes passes the classifier register, a queue entry and the packer
// output register before it is on out_valid.
// When the receiver stalls the output byte holds, the packer stops popping,
// the queue fills and in_stall rises once the classifier register has a bit
// it cannot push. No beat is lost.
// Config: write_enable with reg_index 0 sets target_plane (0 black/white,
// 1 red), index 1 sets line_pixels, the pixels per row (0 acts as 1, above
// MAX_ROW_PIXELS it saturates). Write only while the block is idle.
// Synchronous reset clears the queue, the output register and the packer
// (bit position at the MSB, column zero) and restores target_plane 0 and
// line_pixels 128.
module rgb_to_bitplane_packer_top import rtbp_pkg::*; #(
  parameter int MAX_ROW_PIXELS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             write_enable,
  input  logic             reg_index,
  input  logic [ROW_W-1:0] write_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       blue,
  input  logic [7:0]       green,
  input  logic [7:0]       red,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       packed_bits,
  output logic             row_done
);

  cfg_t cfg;
  logic push;
  logic push_bit;
  logic q_full;
  logic pop;
  logic pop_bit;
  logic q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_plane <= PLANE_BW;
      cfg.line_pixels  <= ROW_W'(128);
    end else if (write_enable) begin
      case (reg_index)
        CFG_TARGET_PLANE: cfg.target_plane <= write_data[0];
        CFG_LINE_PIXELS:  cfg.line_pixels  <= write_data;
        default:          cfg              <= cfg;
      endcase
    end
  end

  rtbp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .blue         (blue),
    .green        (green),
    .red          (red),
    .target_plane (cfg.target_plane),
    .push         (push),
    .push_bit     (push_bit),
    .q_full       (q_full)
  );

  rtbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_bit  (push_bit),
    .full      (q_full),
    .pop       (pop),
    .pop_bit   (pop_bit),
    .not_empty (q_valid)
  );

  rtbp_back #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .line_pixels (cfg.line_pixels),
    .q_valid     (q_valid),
    .q_bit       (pop_bit),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packed_bits (packed_bits),
    .row_done    (row_done)
  );

endmodule
